>>> sv/aes_ctr_pkg.sv
package aes_ctr_pkg;

    localparam int CounterBytes = 4;
    localparam int CtrW = (CounterBytes < 4) ? 8 * CounterBytes : 32;
    localparam int NumRounds = 10;
    localparam int NumLanes = 4;

    // Counter block bits kept from the nonce and counter; a counter field wider
    // than four bytes clears the nonce bytes it covers.
    localparam logic [127:0] CtrBlkMask =
        ~((128'd1 << (8 * CounterBytes)) - 128'd1) | 128'hffffffff;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEYEXP,
        ST_RUN,
        ST_OUT
    } state_t;

    typedef logic [31:0] word_t;

    // Lane control from the sequencer.
    typedef struct packed {
        logic step;
        logic load;
        logic last;
    } lane_ctrl_t;

    localparam logic [1:0] CfgKeyHigh = 2'd0;
    localparam logic [1:0] CfgKeyLow = 2'd1;
    localparam logic [1:0] CfgNonceHigh = 2'd2;
    localparam logic [1:0] CfgNonceMid = 2'd3;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
            8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
            8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
            8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
            8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
            8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
            8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
            8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
            8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
            8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
            8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
            8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
            8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
            8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
            8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
            8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
            8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
            8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
            8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
            8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
            8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
            8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
            8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
            8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
            8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
            8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
            8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
            8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
            8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
            8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
            8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
            8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
            8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
            8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
            8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
            8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
            8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
            8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
            8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
            8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
            8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
            8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
            8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
            8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
            8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
            8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
            8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
            8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
            8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
            8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
            8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
            8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
            8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
            8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
            8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
            8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
            8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
            8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
            8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
            8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
            8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
            8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
            8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
            8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; default: r = 8'h16;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] r);
        logic [7:0] v;
        case (r)
            4'd1: v = 8'h01; 4'd2: v = 8'h02; 4'd3: v = 8'h04; 4'd4: v = 8'h08;
            4'd5: v = 8'h10; 4'd6: v = 8'h20; 4'd7: v = 8'h40; 4'd8: v = 8'h80;
            4'd9: v = 8'h1b; 4'd10: v = 8'h36;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

>>> sv/aes_ctr_ram.sv
module aes_ctr_ram #(
    parameter int Width = 64,
    parameter int Depth = 22
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/aes_ctr_lane.sv
// One column of the AES state: SubBytes input arrives already row-shifted.
module aes_ctr_lane (
    input  logic                   aclk,
    input  aes_ctr_pkg::lane_ctrl_t ctrl,
    input  aes_ctr_pkg::word_t     load_col,
    input  aes_ctr_pkg::word_t     shifted_col,
    input  aes_ctr_pkg::word_t     rkey_col,
    output aes_ctr_pkg::word_t     col
);

    aes_ctr_pkg::word_t col_reg;
    aes_ctr_pkg::word_t col_next;
    logic [7:0] a0, a1, a2, a3, all;
    aes_ctr_pkg::word_t mixed;

    // SubBytes, MixColumns (skipped last round), key add, or load.
    always_comb begin
        a0 = aes_ctr_pkg::sbox(shifted_col[31:24]);
        a1 = aes_ctr_pkg::sbox(shifted_col[23:16]);
        a2 = aes_ctr_pkg::sbox(shifted_col[15:8]);
        a3 = aes_ctr_pkg::sbox(shifted_col[7:0]);
        all = a0 ^ a1 ^ a2 ^ a3;
        mixed = {a0 ^ all ^ aes_ctr_pkg::xtime(a0 ^ a1),
                 a1 ^ all ^ aes_ctr_pkg::xtime(a1 ^ a2),
                 a2 ^ all ^ aes_ctr_pkg::xtime(a2 ^ a3),
                 a3 ^ all ^ aes_ctr_pkg::xtime(a3 ^ a0)};
        if (ctrl.load) begin
            col_next = load_col ^ rkey_col;
        end else if (ctrl.last) begin
            col_next = {a0, a1, a2, a3} ^ rkey_col;
        end else begin
            col_next = mixed ^ rkey_col;
        end
    end

    // The column only advances on a round step.
    always_ff @(posedge aclk) begin
        if (ctrl.step) begin
            col_reg <= col_next;
        end
    end

    assign col = col_reg;

endmodule

>>> sv/aes_ctr_keyexp.sv
// Expands the key into the round key RAM, writing each round key as two 64-bit halves.
module aes_ctr_keyexp (
    input  logic         aclk,
    input  logic         start,
    input  logic [127:0] key,
    output logic         busy,
    output logic         we,
    output logic [4:0]   waddr,
    output logic [63:0]  wdata
);

    logic [127:0] rk_reg, rk_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic         half_reg, half_next;
    logic         busy_reg, busy_next;
    aes_ctr_pkg::word_t t, w0, w1, w2, w3;

    // Next round key from the current one; each key is written as two 64-bit halves.
    always_comb begin
        t = {aes_ctr_pkg::sbox(rk_reg[23:16]) ^ aes_ctr_pkg::rcon(rnd_reg + 4'd1),
             aes_ctr_pkg::sbox(rk_reg[15:8]), aes_ctr_pkg::sbox(rk_reg[7:0]),
             aes_ctr_pkg::sbox(rk_reg[31:24])};
        w0 = rk_reg[127:96] ^ t;
        w1 = rk_reg[95:64] ^ w0;
        w2 = rk_reg[63:32] ^ w1;
        w3 = rk_reg[31:0] ^ w2;
        rk_next = rk_reg;
        rnd_next = rnd_reg;
        half_next = half_reg;
        busy_next = busy_reg;
        if (start) begin
            rk_next = key;
            rnd_next = 4'd0;
            half_next = 1'b0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            half_next = ~half_reg;
            if (half_reg) begin
                if (rnd_reg == 4'(aes_ctr_pkg::NumRounds)) begin
                    busy_next = 1'b0;
                end else begin
                    rk_next = {w0, w1, w2, w3};
                    rnd_next = rnd_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        rk_reg <= rk_next;
        rnd_reg <= rnd_next;
        half_reg <= half_next;
        busy_reg <= busy_next;
    end

    assign busy = busy_reg | start;
    assign we = busy_reg & ~start;
    assign waddr = {rnd_reg, half_reg};
    assign wdata = half_reg ? rk_reg[63:0] : rk_reg[127:64];

endmodule

>>> sv/aes128_ctr_stream_cipher.sv
// Channel   Ports            Payload (lowest bit up)
// s_axis    s_tvalid/tready  tdata: text_high, text_low
// m_axis    m_tvalid/tready  tdata: cipher_high, cipher_low
// cfg       cfg_we/idx/data  key_high, key_low, nonce_high, nonce_mid
// A block passes ST_IDLE, where it is accepted, then ST_KEYEXP, which fetches the
// second half of the first round key, then the load and ten rounds, each a ST_RUN
// and ST_OUT pair, as the 64-bit round key RAM gives a round key in two registered
// reads. The result register loads as the last ST_OUT ends; the next beat can be
// taken in the cycle after. A key write holds off beats while the 22-word schedule
// is rebuilt; expansion also runs once after reset. A result that is still waiting
// at the end of the last round holds the sequencer until it leaves.
module aes128_ctr_stream_cipher (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // text_high, text_low
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // cipher_high, cipher_low
    input  logic         cfg_we,
    input  logic [1:0]   cfg_idx,
    input  logic [63:0]  cfg_data
);

    aes_ctr_pkg::state_t state_reg, state_next;
    logic [63:0]  key_high_reg, key_low_reg, nonce_high_reg;
    logic [31:0]  nonce_mid_reg;
    logic [aes_ctr_pkg::CtrW-1:0] ctr_reg, ctr_next;
    logic [127:0] text_reg;
    logic [127:0] out_reg;
    logic         out_valid_reg, out_valid_next;
    logic         out_load;
    logic [3:0]   rnd_reg, rnd_next;
    logic         kx_start_reg;
    logic         kx_busy, kx_we;
    logic [4:0]   kx_waddr, raddr;
    logic [63:0]  kx_wdata, rk_half;
    logic [63:0]  rk_hi_reg;
    logic         rd_hi_reg;
    logic [127:0] rkey, ctr_blk, state_w, shifted;
    aes_ctr_pkg::lane_ctrl_t ctrl;
    logic         accept;
    logic [31:0]  ctr_w;

    // Configuration registers; a key write restarts expansion.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= '0;
            key_low_reg <= '0;
            nonce_high_reg <= '0;
            nonce_mid_reg <= '0;
            kx_start_reg <= 1'b1;
        end else begin
            kx_start_reg <= 1'b0;
            if (cfg_we) begin
                case (cfg_idx)
                    aes_ctr_pkg::CfgKeyHigh: begin
                        key_high_reg <= cfg_data;
                        kx_start_reg <= 1'b1;
                    end
                    aes_ctr_pkg::CfgKeyLow: begin
                        key_low_reg <= cfg_data;
                        kx_start_reg <= 1'b1;
                    end
                    aes_ctr_pkg::CfgNonceHigh: nonce_high_reg <= cfg_data;
                    aes_ctr_pkg::CfgNonceMid: nonce_mid_reg <= cfg_data[31:0];
                    default: ;
                endcase
            end
        end
    end

    aes_ctr_keyexp u_keyexp (
        .aclk  (aclk),
        .start (kx_start_reg),
        .key   ({key_high_reg, key_low_reg}),
        .busy  (kx_busy),
        .we    (kx_we),
        .waddr (kx_waddr),
        .wdata (kx_wdata)
    );

    aes_ctr_ram #(.Width(64), .Depth(22)) u_rk_ram (
        .aclk  (aclk),
        .we    (kx_we),
        .waddr (kx_waddr),
        .wdata (kx_wdata),
        .raddr (raddr),
        .rdata (rk_half)
    );

    // Round keys are read as two halves; the high half is held in rk_hi_reg while the low half is read.
    always_ff @(posedge aclk) begin
        rd_hi_reg <= ~raddr[0];
        if (rd_hi_reg) begin
            rk_hi_reg <= rk_half;
        end
    end
    assign rkey = {rk_hi_reg, rk_half};

    assign ctr_w = 32'(ctr_reg);
    assign ctr_blk = {nonce_high_reg, nonce_mid_reg, ctr_w} & aes_ctr_pkg::CtrBlkMask;
    assign accept = s_tvalid & s_tready;
    assign s_tready = (state_reg == aes_ctr_pkg::ST_IDLE) & ~kx_busy;

    // ShiftRows: column c takes row i from column c+i.
    always_comb begin
        for (int c = 0; c < aes_ctr_pkg::NumLanes; c++) begin
            for (int i = 0; i < 4; i++) begin
                shifted[127 - 32*c - 8*i -: 8] = state_w[127 - 32*((c+i)%4) - 8*i -: 8];
            end
        end
    end

    for (genvar g = 0; g < aes_ctr_pkg::NumLanes; g++) begin : g_lane
        aes_ctr_lane u_lane (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .load_col    (ctr_blk[127 - 32*g -: 32]),
            .shifted_col (shifted[127 - 32*g -: 32]),
            .rkey_col    (rkey[127 - 32*g -: 32]),
            .col         (state_w[127 - 32*g -: 32])
        );
    end

    // Keystream bytes 0..7 meet text_high in the low half of tdata.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= aes_ctr_pkg::ST_IDLE;
            ctr_reg <= '0;
            out_valid_reg <= 1'b0;
            rnd_reg <= '0;
        end else begin
            state_reg <= state_next;
            ctr_reg <= ctr_next;
            out_valid_reg <= out_valid_next;
            rnd_reg <= rnd_next;
        end
        if (accept) begin
            text_reg <= s_tdata;
        end
        if (out_load) begin
            out_reg <= {text_reg[127:64] ^ state_w[63:0], text_reg[63:0] ^ state_w[127:64]};
        end
    end

    // Sequencer: fetch key half pairs, step the lanes, merge into the output and advance the counter.
    always_comb begin
        state_next = state_reg;
        ctr_next = ctr_reg;
        rnd_next = rnd_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        out_load = 1'b0;
        ctrl = '0;
        raddr = {rnd_reg, 1'b0};
        case (state_reg)
            aes_ctr_pkg::ST_IDLE: begin
                raddr = 5'd0;
                if (accept) begin
                    state_next = aes_ctr_pkg::ST_KEYEXP;
                    rnd_next = 4'd0;
                end
            end
            aes_ctr_pkg::ST_KEYEXP: begin
                // Second key half for round zero, then load the lanes.
                raddr = 5'd1;
                state_next = aes_ctr_pkg::ST_RUN;
            end
            aes_ctr_pkg::ST_RUN: begin
                ctrl.step = 1'b1;
                ctrl.load = (rnd_reg == 4'd0);
                ctrl.last = (rnd_reg == 4'(aes_ctr_pkg::NumRounds));
                raddr = {rnd_reg + 4'd1, 1'b0};
                state_next = aes_ctr_pkg::ST_OUT;
            end
            aes_ctr_pkg::ST_OUT: begin
                if (rnd_reg == 4'(aes_ctr_pkg::NumRounds)) begin
                    if (!out_valid_reg || m_tready) begin
                        out_load = 1'b1;
                        out_valid_next = 1'b1;
                        ctr_next = ctr_reg + 1'b1;
                        state_next = aes_ctr_pkg::ST_IDLE;
                    end
                    raddr = 5'd0;
                end else begin
                    raddr = {rnd_reg + 4'd1, 1'b1};
                    rnd_next = rnd_reg + 4'd1;
                    state_next = aes_ctr_pkg::ST_RUN;
                end
            end
            default: state_next = aes_ctr_pkg::ST_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg;

endmodule
